// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: src/frp_pkg.sv
// ---------------------------------------------------------------------------
// frp_pkg
// shared codes and types for the range-purge fifo
// ---------------------------------------------------------------------------
package frp_pkg;

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_PURGE   = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int DATA_W = 32;

    typedef enum logic {
        S_IDLE,
        S_PURGE
    } state_t;

    // per-cycle operation broadcast to every cell of the chain
    typedef struct packed {
        logic shift;   // every cell takes its upper neighbor unless load selects it
        logic load;    // the selected cell takes the shared input
        logic recirc;  // shared input is the head cell (purge walk)
    } chain_op_t;

endpackage

// File: src/frp_cell.sv
// ---------------------------------------------------------------------------
// frp_cell
// one storage cell of the chain: hold, shift from neighbor, or load
// ---------------------------------------------------------------------------
module frp_cell
    import frp_pkg::*;
(
    input  logic                     clk,
    input  chain_op_t                op,
    input  logic                     sel,
    input  logic signed [DATA_W-1:0] din,
    input  logic signed [DATA_W-1:0] nbr,
    output logic signed [DATA_W-1:0] q
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     wr;

    assign wr = op.load && sel;

    always_comb
    begin
        if (op.shift)
        begin
            value_next = wr ? din : nbr;
        end
        else if (wr)
        begin
            value_next = din;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign q = value_reg;

endmodule

// File: src/frp_ctrl.sv
// ---------------------------------------------------------------------------
// frp_ctrl
// command decode, fill count, purge walk sequencer and result register
// ---------------------------------------------------------------------------
module frp_ctrl
    import frp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               command,
    input  logic signed [DATA_W-1:0] data_value,
    input  logic signed [DATA_W-1:0] bound_a,
    input  logic signed [DATA_W-1:0] bound_b,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] head_value,
    output logic [CW-1:0]            fill_level,
    input  logic signed [DATA_W-1:0] head_in,
    output chain_op_t                op,
    output logic [CW-1:0]            wr_idx,
    output logic signed [DATA_W-1:0] din
);

    state_t                   state_reg,  state_next;
    logic [CW-1:0]            count_reg,  count_next;
    logic [CW-1:0]            left_reg,   left_next;
    logic signed [DATA_W-1:0] lo_reg,     lo_next;
    logic signed [DATA_W-1:0] hi_reg,     hi_next;
    logic                     ovld_reg,   ovld_next;
    logic [1:0]               status_reg, status_next;
    logic signed [DATA_W-1:0] head_reg,   head_next;
    logic [CW-1:0]            fill_reg;
    logic                     accept;
    logic                     out_load;
    logic                     keep;

    assign in_ready = (state_reg == S_IDLE) && (!ovld_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign keep     = (head_in < lo_reg) || (head_in > hi_reg);
    assign din      = op.recirc ? head_in : data_value;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        left_next   = left_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        ovld_next   = ovld_reg && !out_ready;
        status_next = status_reg;
        head_next   = head_reg;
        out_load    = 1'b0;
        op          = '0;
        wr_idx      = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_load    = 1'b1;
                    status_next = ST_DONE;
                    head_next   = '0;
                    unique case (command)
                        CMD_ENQUEUE:
                        begin
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                op.load    = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                op.shift   = 1'b1;
                                head_next  = head_in;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        CMD_PURGE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // result comes at the end of the walk
                                out_load   = 1'b0;
                                lo_next    = (bound_a < bound_b) ? bound_a : bound_b;
                                hi_next    = (bound_a < bound_b) ? bound_b : bound_a;
                                left_next  = count_reg;
                                state_next = S_PURGE;
                            end
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_PURGE:
            begin
                // pop head; a survivor re-enters at the tail of the chain
                op.shift  = 1'b1;
                op.recirc = 1'b1;
                wr_idx    = count_reg - CW'(1);
                if (keep)
                begin
                    op.load = 1'b1;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
                left_next = left_reg - CW'(1);
                if (left_reg == CW'(1))
                begin
                    state_next  = S_IDLE;
                    out_load    = 1'b1;
                    status_next = ST_DONE;
                    head_next   = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            ovld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            left_reg  <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        status_reg <= status_next;
        head_reg   <= head_next;
        if (out_load)
        begin
            fill_reg <= count_next;
        end
    end

    assign out_valid  = ovld_reg;
    assign status     = status_reg;
    assign head_value = head_reg;
    assign fill_level = fill_reg;

endmodule

// File: src/fifo_with_range_purge.sv
// ---------------------------------------------------------------------------
// fifo_with_range_purge
// bounded fifo of signed 32-bit values with enqueue, dequeue, range purge
// ---------------------------------------------------------------------------
// input channel: in_valid/in_ready carry command, data_value, bound_a, bound_b
// output channel: out_valid/out_ready carry status, head_value, fill_level
// one result transaction per input transaction, in order
// storage is a chain of cells with the head in cell 0; dequeue shifts the
// whole chain down by one, enqueue loads the cell at the fill level
// enqueue, dequeue and unused codes: the result is registered and shown in
// the cycle after acceptance; one command per cycle while the receiver keeps up
// purge: walks the chain, one entry per cycle, popping the head and loading
// survivors back at the tail; the result comes once the last entry stored
// before the purge is walked; input is held off meanwhile
// a stalled result holds the output register and blocks new input only
// once the register is full and out_ready stays low
// reset empties the queue and the output register; cell contents stay
// undefined until written
// ---------------------------------------------------------------------------
module fifo_with_range_purge
    import frp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             command,
    input  logic signed [DATA_W-1:0]               data_value,
    input  logic signed [DATA_W-1:0]               bound_a,
    input  logic signed [DATA_W-1:0]               bound_b,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [1:0]                             status,
    output logic signed [DATA_W-1:0]               head_value,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0]     fill_level
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    chain_op_t                op;
    logic [CW-1:0]            wr_idx;
    logic signed [DATA_W-1:0] din;
    logic signed [DATA_W-1:0] cell_q [QUEUE_DEPTH];

    frp_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .data_value (data_value),
        .bound_a    (bound_a),
        .bound_b    (bound_b),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .head_value (head_value),
        .fill_level (fill_level),
        .head_in    (cell_q[0]),
        .op         (op),
        .wr_idx     (wr_idx),
        .din        (din)
    );

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] nbr;

        if (i == QUEUE_DEPTH - 1)
        begin : g_top
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_q[i + 1];
        end

        frp_cell u_cell (
            .clk (clk),
            .op  (op),
            .sel (wr_idx == CW'(i)),
            .din (din),
            .nbr (nbr),
            .q   (cell_q[i])
        );
    end

endmodule

// File: src/frp_checker.sv
// ---------------------------------------------------------------------------
// frp_checker
// port-level checks on the range-purge fifo, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frp_checker
    import frp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [1:0]                          status,
    input logic signed [DATA_W-1:0]            head_value,
    input logic [$clog2(QUEUE_DEPTH + 1)-1:0]  fill_level
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // a stalled result blocks new transactions
    `ASSERT_IMPLIES(a_stall_blocks, out_valid && !out_ready, !in_ready)
    // full report only at capacity
    `ASSERT_IMPLIES(a_full_level, out_valid && status == ST_FULL, fill_level == CW'(QUEUE_DEPTH))
    // empty report only with nothing stored
    `ASSERT_IMPLIES(a_empty_level, out_valid && status == ST_EMPTY, fill_level == '0)
    // a returned value comes only from a completed dequeue
    `ASSERT_IMPLIES(a_head_done, out_valid && head_value != '0, status == ST_DONE)
    // each accepted transaction yields a result in the next cycle or later
    `ASSERT_NEXT(a_accept_result, in_valid && in_ready, out_valid || !in_ready)

endmodule

bind fifo_with_range_purge frp_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_frp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .head_value (head_value),
    .fill_level (fill_level)
);
